>>> design/shs_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Request types, control structs, state encodings and the SHA-256 constants
// shared by the hasher modules.
// ----------------------------------------------------------------------------
package shs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       is_last;
  } shs_in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } shs_out_req_t;

  // Eight 32-bit words; index 0 is the first chaining word (a).
  typedef logic [7:0][31:0] shs_vars_t;

  typedef struct packed {
    logic       load;
    logic [7:0] load_byte;
    logic       start;
    logic       restart;
  } shs_core_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_HASH,
    ST_OUT
  } shs_top_e;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_ADD
  } shs_core_e;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam shs_vars_t SHS_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] shs_round_const(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

>>> design/sha256_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the digest as eight 32-bit words.
//
//   Channel  Direction  Handshake                  Payload
//   in       request    in_valid_i / in_stall_o    shs_in_req_t  (one byte)
//   out      response   out_valid_o / out_stall_i  shs_out_req_t (digest word)
//
// A byte that does not fill the block is taken without a stall. A byte that
// fills the block stalls the input for a compression: 64 rounds on the
// shared round unit, then the chaining add. The last request adds the
// padding and length bytes (at most 72 bytes), one or two compressions,
// and eight output words, each held as long as out_stall_i is high.
// Reset loads the initial hash values and clears the byte counts.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit import shs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  shs_in_req_t  in_req_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output shs_out_req_t out_req_o
);

  shs_top_e      state_q, state_d;
  shs_top_e      ret_q, ret_d;
  logic [5:0]    fill_q, fill_d;
  logic [63:0]   total_q, total_d;
  logic          first_q, first_d;
  logic [2:0]    oidx_q, oidx_d;
  shs_core_req_t core_req;
  logic          core_done;
  shs_vars_t     chain;
  logic [63:0]   bit_len;
  logic          in_fire;
  logic          out_fire;

  shs_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (core_req),
    .done_o  (core_done),
    .chain_o (chain)
  );

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;
  assign bit_len  = {total_q[60:0], 3'b000};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req_i.byte_present && fill_q == 6'd63) begin
            state_d = ST_HASH;
          end else if (in_req_i.is_last) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill_q == 6'd63) begin
          state_d = ST_HASH;
        end else if (fill_q == 6'd55) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        if (fill_q == 6'd63) begin
          state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        if (core_done) begin
          state_d = ret_q;
        end
      end
      ST_OUT: begin
        if (out_fire && oidx_q == 3'd7) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ret_d              = ret_q;
    fill_d             = fill_q;
    total_d            = total_q;
    first_d            = first_q;
    oidx_d             = oidx_q;
    core_req.load      = 1'b0;
    core_req.load_byte = in_req_i.data_byte;
    core_req.start     = 1'b0;
    core_req.restart   = 1'b0;
    in_stall_o         = 1'b1;
    out_valid_o        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_fire) begin
          first_d = 1'b1;
          if (in_req_i.byte_present) begin
            core_req.load = 1'b1;
            fill_d        = fill_q + 6'd1;
            total_d       = total_q + 64'd1;
            if (fill_q == 6'd63) begin
              core_req.start = 1'b1;
              ret_d          = in_req_i.is_last ? ST_PAD : ST_IDLE;
            end
          end
        end
      end
      ST_PAD: begin
        core_req.load      = 1'b1;
        core_req.load_byte = first_q ? PAD_MARK : 8'h00;
        first_d            = 1'b0;
        fill_d             = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          core_req.start = 1'b1;
          ret_d          = ST_PAD;
        end
      end
      ST_LEN: begin
        core_req.load      = 1'b1;
        core_req.load_byte = bit_len[{~fill_q[2:0], 3'b000} +: 8];
        fill_d             = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          core_req.start = 1'b1;
          ret_d          = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_fire) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            core_req.restart = 1'b1;
            total_d          = '0;
            fill_d           = '0;
          end
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign out_req_o.digest_word = chain[oidx_q];
  assign out_req_o.word_index  = oidx_q;
  assign out_req_o.last_word   = (oidx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      fill_q  <= '0;
      total_q <= '0;
      first_q <= 1'b0;
      oidx_q  <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      first_q <= first_d;
      oidx_q  <= oidx_d;
    end
  end

endmodule

>>> design/shs_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round on the working words and the next message schedule
// word from the sliding sixteen-word window.
// ----------------------------------------------------------------------------
module shs_round import shs_pkg::*; (
  input  shs_vars_t   vars_i,
  input  logic [31:0] k_i,
  input  logic [31:0] w0_i,
  input  logic [31:0] w1_i,
  input  logic [31:0] w9_i,
  input  logic [31:0] w14_i,
  output shs_vars_t   vars_o,
  output logic [31:0] w_new_o
);

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  logic [31:0] choose;
  logic [31:0] major;
  logic [31:0] sum1;
  logic [31:0] sum2;

  always_comb begin
    choose = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
    major  = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
    sum1   = vars_i[7] + big_sigma1(vars_i[4]) + choose + k_i + w0_i;
    sum2   = big_sigma0(vars_i[0]) + major;
    vars_o[7] = vars_i[6];
    vars_o[6] = vars_i[5];
    vars_o[5] = vars_i[4];
    vars_o[4] = vars_i[3] + sum1;
    vars_o[3] = vars_i[2];
    vars_o[2] = vars_i[1];
    vars_o[1] = vars_i[0];
    vars_o[0] = sum1 + sum2;
  end

  assign w_new_o = small_sigma1(w14_i) + w9_i + small_sigma0(w1_i) + w0_i;

endmodule

>>> design/shs_core.sv
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Holds the block window, the working words and the chaining words, and runs
// one round per cycle through the shared round unit, then the final add.
// ----------------------------------------------------------------------------
module shs_core import shs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  shs_core_req_t req_i,
  output logic          done_o,
  output shs_vars_t     chain_o
);

  shs_core_e   state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [511:0] win_q, win_d;
  shs_vars_t   vars_q, vars_d;
  shs_vars_t   chain_q, chain_d;
  shs_vars_t   vars_next;
  logic [31:0] w_new;
  logic        round_en;

  shs_round u_round (
    .vars_i  (vars_q),
    .k_i     (shs_round_const(cnt_q)),
    .w0_i    (win_q[511 -: 32]),
    .w1_i    (win_q[479 -: 32]),
    .w9_i    (win_q[223 -: 32]),
    .w14_i   (win_q[63 -: 32]),
    .vars_o  (vars_next),
    .w_new_o (w_new)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      CORE_IDLE: begin
        if (req_i.start) begin
          state_d = CORE_ROUND;
        end
      end
      CORE_ROUND: begin
        if (cnt_q == 6'd63) begin
          state_d = CORE_ADD;
        end
      end
      CORE_ADD: begin
        state_d = CORE_IDLE;
      end
      default: state_d = CORE_IDLE;
    endcase
  end

  always_comb begin
    round_en = 1'b0;
    done_o   = 1'b0;
    case (state_q)
      CORE_ROUND: round_en = 1'b1;
      CORE_ADD:   done_o   = 1'b1;
      default: begin
        round_en = 1'b0;
        done_o   = 1'b0;
      end
    endcase
  end

  always_comb begin
    win_d   = win_q;
    vars_d  = vars_q;
    cnt_d   = cnt_q;
    chain_d = chain_q;
    if (req_i.load) begin
      win_d = {win_q[503:0], req_i.load_byte};
    end else if (round_en) begin
      win_d = {win_q[479:0], w_new};
    end
    if (req_i.start) begin
      vars_d = chain_q;
      cnt_d  = '0;
    end else if (round_en) begin
      vars_d = vars_next;
      cnt_d  = cnt_q + 6'd1;
    end
    if (req_i.restart) begin
      chain_d = SHS_IV;
    end else if (done_o) begin
      for (int i = 0; i < 8; i++) begin
        chain_d[i] = chain_q[i] + vars_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CORE_IDLE;
      cnt_q   <= '0;
      chain_q <= SHS_IV;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    vars_q <= vars_d;
  end

  assign chain_o = chain_q;

endmodule

>>> tb/sv/sha256_stream_hasher_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte requests with random gaps and receiver stalls into the hasher and
// checks every digest word against a SHA-256 predictor kept in the testbench.
// Directed messages open the run, then random messages of mixed lengths
// follow, mostly short ones and many around the block and padding boundaries.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit_test;
  import shs_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 355;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned TAIL_CYCLES  = 300;
  localparam int unsigned REPORT_MAX   = 10;
  localparam logic [7:0]  PAD_BYTE     = 8'h80;

  localparam logic [0:7][31:0] HASH_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic         clk_i = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  shs_in_req_t  in_req = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  shs_out_req_t out_req;

  shs_in_req_t  request_q [$];
  shs_out_req_t pending_digest_words [$];

  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  int unsigned fill;
  logic [63:0] total_len;

  bit          in_taken = 1'b0;
  int unsigned requests_taken = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned stall_left = 0;
  int unsigned recv_calm = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;

  sha256_stream_hasher_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void sha_compress();
    logic [31:0] sched [64];
    logic [31:0] v [8];
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] t1;
    logic [31:0] t2;
    for (int r = 0; r < 16; r++) begin
      sched[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
    end
    for (int r = 16; r < 64; r++) begin
      lo = rotr32(sched[r-15], 7) ^ rotr32(sched[r-15], 18) ^ (sched[r-15] >> 3);
      hi = rotr32(sched[r-2], 17) ^ rotr32(sched[r-2], 19) ^ (sched[r-2] >> 10);
      sched[r] = sched[r-16] + lo + sched[r-7] + hi;
    end
    for (int r = 0; r < 8; r++) begin
      v[r] = chain[r];
    end
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + sched[r];
      t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int r = 0; r < 8; r++) begin
      chain[r] = chain[r] + v[r];
    end
  endfunction

  function automatic void sha_restart();
    for (int j = 0; j < 8; j++) begin
      chain[j] = HASH_INIT[j];
    end
    fill = 0;
    total_len = '0;
  endfunction

  // Absorbs one accepted request; a last request queues the eight digest words.
  function automatic void sha_absorb_request(input shs_in_req_t req);
    int unsigned pos;
    logic [63:0] bitlen;
    shs_out_req_t word;
    if (req.byte_present) begin
      blk[fill] = req.data_byte;
      fill++;
      total_len++;
      if (fill == 64) begin
        sha_compress();
        fill = 0;
      end
    end
    if (!req.is_last) return;
    pos = fill;
    blk[pos] = PAD_BYTE;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        blk[pos] = 8'h00;
        pos++;
      end
      sha_compress();
      pos = 0;
    end
    while (pos < 56) begin
      blk[pos] = 8'h00;
      pos++;
    end
    bitlen = total_len << 3;
    for (int j = 0; j < 8; j++) begin
      blk[56+j] = bitlen[63-8*j -: 8];
    end
    sha_compress();
    for (int j = 0; j < 8; j++) begin
      word.digest_word = chain[j];
      word.word_index  = 3'(j);
      word.last_word   = (j == 7);
      pending_digest_words.push_back(word);
    end
    sha_restart();
  endfunction

  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_request(input logic [7:0] data, input logic present, input logic last);
    shs_in_req_t req;
    req.data_byte    = data;
    req.byte_present = present;
    req.is_last      = last;
    request_q.push_back(req);
  endtask

  task automatic report_word(input bit have_want, input shs_out_req_t got,
                             input shs_out_req_t want);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      if (have_want) begin
        $display("digest word mismatch at cycle %0d: got %h idx %0d last %0b, expected %h idx %0d last %0b",
                 cycle_count, got.digest_word, got.word_index, got.last_word,
                 want.digest_word, want.word_index, want.last_word);
      end else begin
        $display("unexpected digest word at cycle %0d: %h idx %0d last %0b",
                 cycle_count, got.digest_word, got.word_index, got.last_word);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_n && in_valid && !in_stall) begin
      sha_absorb_request(in_req);
      requests_taken <= requests_taken + 1;
      in_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        in_req   <= request_q.pop_front();
        in_valid <= 1'b1;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = idle_length();
          if ($urandom_range(0, 29) == 0) send_calm = $urandom_range(20, 60);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver holds off twice for a long stretch so the block backs up.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && requests_taken >= 60) ||
                 (holds_done == 1 && requests_taken >= 250)) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (recv_calm > 0) begin
      recv_calm--;
      out_stall <= 1'b0;
    end else begin
      stall_left = idle_length();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
      if ($urandom_range(0, 29) == 0) recv_calm = $urandom_range(20, 60);
    end
  end

  always @(posedge clk_i) begin
    shs_out_req_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_digest_words.size() == 0) begin
        report_word(1'b0, out_req, out_req);
      end else begin
        want = pending_digest_words.pop_front();
        if (out_req.digest_word !== want.digest_word ||
            out_req.word_index !== want.word_index ||
            out_req.last_word !== want.last_word) begin
          report_word(1'b1, out_req, want);
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("sha256_stream_hasher_unit test failed");
    $finish;
  end

  initial begin
    int unsigned counted;
    int unsigned roll;
    int unsigned msg_len;
    bit          tail_byte;

    sha_restart();
    for (int j = 0; j < 64; j++) begin
      blk[j] = 8'h00;
    end

    // Empty message, then "abc" ending on its last byte.
    add_request(8'h5a, 1'b0, 1'b1);
    add_request(8'h61, 1'b1, 1'b0);
    add_request(8'h62, 1'b1, 1'b0);
    add_request(8'h63, 1'b1, 1'b1);
    // Byte extremes, idle requests inside a message and a last without a byte.
    add_request(8'h00, 1'b1, 1'b0);
    add_request(8'hff, 1'b0, 1'b0);
    add_request(8'hff, 1'b1, 1'b0);
    add_request(8'h00, 1'b0, 1'b0);
    add_request(8'ha5, 1'b0, 1'b1);
    add_request(8'hff, 1'b1, 1'b1);
    add_request(8'h00, 1'b1, 1'b1);
    counted = 11;

    while (counted < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) msg_len = $urandom_range(0, 12);
      else if (roll < 80) msg_len = $urandom_range(52, 66);
      else if (roll < 93) msg_len = $urandom_range(13, 40);
      else msg_len = $urandom_range(100, 140);
      tail_byte = (msg_len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < msg_len; i++) begin
        if ($urandom_range(0, 11) == 0) add_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        add_request(8'($urandom_range(0, 255)), 1'b1, tail_byte && (i == msg_len - 1));
        counted++;
      end
      if (!tail_byte) begin
        add_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        counted++;
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    wait (request_q.size() == 0 && !in_valid);
    wait (pending_digest_words.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_digest_words.size() == 0) begin
      $display("sha256_stream_hasher_unit test passed");
    end else begin
      $display("sha256_stream_hasher_unit test failed");
    end
    $finish;
  end

endmodule
